// ===== design/assert_macros.svh =====
// Assertion macros shared by the PID block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle, checked on clk outside of reset.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequence must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ppid_pkg.sv =====
// Package with the widths, register codes, types and helpers of the PID block.
package ppid_pkg;

  // Field and datapath widths.
  localparam int unsigned POS_W      = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned DZ_W       = 16;
  localparam int unsigned START_W    = 17;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned ERR_W      = POS_W + 1;
  localparam int unsigned DIFF_W     = ERR_W + 1;
  localparam int unsigned PROD_W     = GAIN_W + DIFF_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DRIVE_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register reset values.
  localparam logic [DZ_W-1:0]    DEAD_ZONE_RST   = 16'd60;
  localparam logic [START_W-1:0] INTEG_START_RST = 17'd200;
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 16'd800;

  // Saturation bounds of the drive value.
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_DEAD_ZONE      = 3'd3,
    CFG_INTEG_START    = 3'd4,
    CFG_INTEG_LIMIT    = 3'd5
  } cfg_idx_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [DZ_W-1:0]          dead_zone;
    logic [START_W-1:0]       integral_start;
    logic [LIMIT_W-1:0]       integral_limit;
  } cfg_t;

  // Terms handed from the error stage to the multiply stage.
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W-1:0]  integ;
    logic signed [DIFF_W-1:0] diff;
  } term_t;

  // Floor shift out the fraction bits and saturate to the drive width.
  function automatic logic signed [DRIVE_W-1:0] shift_sat(
    input logic signed [SUM_W-1:0] sum
  );
    logic signed [SUM_W-1:0] sh;
    logic signed [DRIVE_W-1:0] res;
    sh = sum >>> FRAC_W;
    if (sh > SUM_W'(DRIVE_MAX)) begin
      res = DRIVE_MAX;
    end else if (sh < SUM_W'(DRIVE_MIN)) begin
      res = DRIVE_MIN;
    end else begin
      res = DRIVE_W'(sh);
    end
    return res;
  endfunction

endpackage

// ===== design/ppid_ifs.sv =====
// Valid/ready channel interfaces for the PID sample input and drive output.
interface ppid_in_if import ppid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] target;
  logic signed [POS_W-1:0] measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink (input valid, input target, input measured, output ready);
endinterface

interface ppid_out_if import ppid_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

// ===== design/position_pid_deadzone_antiwindup.sv =====
// Top level of the positional PID controller with dead zone and integral anti-windup.
// Each transfer on the input channel carries a target and a measured position and yields
// one saturated 32-bit drive value via the input, term, product and output registers. A new
// sample can be taken in every cycle while the output is not stalled: the integral and the
// previous error are updated in the single error stage, so one sample per cycle is the
// sustained rate. Gains are signed Q8.16; the integral only accumulates when the error
// magnitude is below integral_start and is clamped to +/- integral_limit; errors within
// the dead zone clear the history. The user must write the configuration registers through
// cfg_write, cfg_index and cfg_data only while the block is idle, which it does not enforce.
`include "assert_macros.svh"

module position_pid_deadzone_antiwindup import ppid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ppid_in_if.sink               in,
  ppid_out_if.source            out
);

  cfg_t  cfg;
  logic  term_valid;
  logic  term_ready;
  term_t term;

  // Configuration registers.
  ppid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register and error stage.
  ppid_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in         (in),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term       (term)
  );

  // Multiply, sum and output stages.
  ppid_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term       (term),
    .out        (out)
  );

  `ASSERT_NOW(a_stall_from_output, !in.ready, out.valid && !out.ready,
    "input stalled while the output can take a transfer")
  `ASSERT_NOW(a_term_stall, term_valid && !term_ready, out.valid && !out.ready,
    "term stage stalled while the output can take a transfer")

endmodule

// ===== design/ppid_cfg.sv =====
// Configuration register file of the PID block.
module ppid_cfg import ppid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Decode the register index; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= '0;
      cfg.gain_i         <= '0;
      cfg.gain_d         <= '0;
      cfg.dead_zone      <= DEAD_ZONE_RST;
      cfg.integral_start <= INTEG_START_RST;
      cfg.integral_limit <= INTEG_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P:      cfg.gain_p         <= GAIN_W'(cfg_data);
        CFG_GAIN_I:      cfg.gain_i         <= GAIN_W'(cfg_data);
        CFG_GAIN_D:      cfg.gain_d         <= GAIN_W'(cfg_data);
        CFG_DEAD_ZONE:   cfg.dead_zone      <= cfg_data[DZ_W-1:0];
        CFG_INTEG_START: cfg.integral_start <= cfg_data[START_W-1:0];
        CFG_INTEG_LIMIT: cfg.integral_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/ppid_front.sv =====
// Input register and error stage: dead zone, integral update and derivative term.
`include "assert_macros.svh"

module ppid_front import ppid_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  ppid_in_if.sink in,
  output logic  term_valid,
  input  logic  term_ready,
  output term_t term
);

  logic                    in_full;
  logic signed [POS_W-1:0] target_q;
  logic signed [POS_W-1:0] measured_q;
  logic                    stage_ready;
  logic                    move;

  logic signed [ERR_W-1:0]  integ_acc;
  logic signed [ERR_W-1:0]  prev_err;

  logic signed [ERR_W-1:0]  err_raw;
  logic [ERR_W-1:0]         mag;
  logic                     in_dz;
  logic signed [ERR_W-1:0]  err_z;
  logic [ERR_W-1:0]         mag_z;
  logic signed [ERR_W-1:0]  integ_base;
  logic signed [ERR_W-1:0]  prev_base;
  logic                     do_int;
  logic signed [DIFF_W-1:0] acc_sum;
  logic signed [DIFF_W-1:0] lim;
  logic signed [ERR_W-1:0]  acc_clamp;
  logic signed [ERR_W-1:0]  integ_new;
  logic signed [DIFF_W-1:0] diff;

  // Each register advances when it is empty or its content moves on.
  assign stage_ready = !term_valid || term_ready;
  assign in.ready    = !in_full || stage_ready;
  assign move        = in_full && stage_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in.ready) begin
      in_full <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      target_q   <= in.target;
      measured_q <= in.measured;
    end
  end

  // Error, magnitude and dead-zone test.
  always_comb begin
    err_raw    = ERR_W'(target_q) - ERR_W'(measured_q);
    mag        = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : err_raw;
    in_dz      = mag <= ERR_W'(cfg.dead_zone);
    err_z      = in_dz ? '0 : err_raw;
    mag_z      = in_dz ? '0 : mag;
    integ_base = in_dz ? '0 : integ_acc;
    prev_base  = in_dz ? '0 : prev_err;
  end

  // Integral separation and clamp, then the error difference.
  always_comb begin
    do_int  = mag_z < cfg.integral_start;
    acc_sum = DIFF_W'(integ_base) + DIFF_W'(err_z);
    lim     = DIFF_W'({1'b0, cfg.integral_limit});
    if (acc_sum > lim) begin
      acc_clamp = ERR_W'(lim);
    end else if (acc_sum < -lim) begin
      acc_clamp = ERR_W'(-lim);
    end else begin
      acc_clamp = ERR_W'(acc_sum);
    end
    integ_new = do_int ? acc_clamp : integ_base;
    diff      = DIFF_W'(err_z) - DIFF_W'(prev_base);
  end

  // Controller history, updated as each sample passes this stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc <= '0;
      prev_err  <= '0;
    end else if (move) begin
      integ_acc <= integ_new;
      prev_err  <= err_z;
    end
  end

  // Term register toward the multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else if (stage_ready) begin
      term_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      term.err   <= err_z;
      term.integ <= integ_new;
      term.diff  <= diff;
    end
  end

  `ASSERT_NEXT(a_dead_zone_clears, move && in_dz, integ_acc == '0 && prev_err == '0,
    "dead zone did not clear the history")
  `ASSERT_NEXT(a_prev_tracks_err, move, prev_err == term.err && integ_acc == term.integ,
    "history differs from the transferred terms")

endmodule

// ===== design/ppid_back.sv =====
// Multiply stage, sum with floor shift and saturation, and the output register.
module ppid_back import ppid_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  term_valid,
  output logic  term_ready,
  input  term_t term,
  ppid_out_if.source out
);

  logic                     prod_full;
  logic                     prod_ready;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  sum;

  // Handshake between the product and output registers.
  assign prod_ready = !out.valid || out.ready;
  assign term_ready = !prod_full || prod_ready;

  // One multiplier per term, registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_full <= 1'b0;
    end else if (term_ready) begin
      prod_full <= term_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (term_valid && term_ready) begin
      prod_p <= PROD_W'(cfg.gain_p) * PROD_W'(term.err);
      prod_i <= PROD_W'(cfg.gain_i) * PROD_W'(term.integ);
      prod_d <= PROD_W'(cfg.gain_d) * PROD_W'(term.diff);
    end
  end

  // Sum of the three products.
  assign sum = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

  // Output register holds the result until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (prod_ready) begin
      out.valid <= prod_full;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_full && prod_ready) begin
      out.drive <= shift_sat(sum);
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the positional PID block with dead zone and integral clamp.
module tb_top;
  import ppid_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_PHASES = 14;
  localparam int unsigned PHASE_SAMPLES = 100;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
  localparam int POS_MIN = -(1 << (POS_W - 1));

  // Register indexes past the last register; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // One step of the directed part: a register write or a sample, with an optional
  // drive value that is typed in by hand.
  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     data;
    logic signed [POS_W-1:0]   tgt;
    logic signed [POS_W-1:0]   meas;
    logic                      known;
    logic signed [DRIVE_W-1:0] drive;
  } dir_row_t;

  localparam int DIR_ROWS = 39;

  // Sample rows carry an unused index field of CFG_GAIN_P.
  dir_row_t directed_tbl [DIR_ROWS] = '{
    // All gains are zero after reset.
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd100, 16'sd0, 1'b1, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sh8000, 16'sh7FFF, 1'b1, 32'sd0},
    // Unity proportional gain at the widest errors and at the dead zone edge.
    '{ROW_WRITE, CFG_GAIN_P, 24'h010000, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sh7FFF, 16'sh8000, 1'b1, 32'sd65535},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sh8000, 16'sh7FFF, 1'b1, -32'sd65535},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd60, 16'sd0, 1'b1, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd0, 16'sd61, 1'b1, -32'sd61},
    // Smallest gain: a negative sum rounds toward minus infinity.
    '{ROW_WRITE, CFG_GAIN_P, 24'h000001, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd0, 16'sd61, 1'b1, -32'sd1},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd61, 16'sd0, 1'b1, 32'sd0},
    // Most negative and most positive gains.
    '{ROW_WRITE, CFG_GAIN_P, 24'h800000, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sh7FFF, 16'sh8000, 1'b1, -32'sd8388480},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sh8000, 16'sh7FFF, 1'b1, 32'sd8388480},
    '{ROW_WRITE, CFG_GAIN_P, 24'h7FFFFF, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sh7FFF, 16'sh8000, 1'b1, 32'sd8388479},
    // Derivative term alone, then the dead zone clears the previous error.
    '{ROW_WRITE, CFG_GAIN_P, 24'h000000, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_WRITE, CFG_GAIN_D, 24'h010000, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd1000, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd1000, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd0, 16'sd0, 1'b1, 32'sd0},
    // Integral term with a zero threshold: nothing is integrated.
    '{ROW_WRITE, CFG_GAIN_D, 24'h000000, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_WRITE, CFG_GAIN_I, 24'h010000, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_WRITE, CFG_INTEG_START, 24'h000000, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd100, 16'sd0, 1'b0, 32'sd0},
    // Wind up the integral, then lower the limit below the held value.
    '{ROW_WRITE, CFG_INTEG_START, 24'h0007D0, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_WRITE, CFG_INTEG_LIMIT, 24'h00FFFF, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd1500, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd1500, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd1500, 16'sd0, 1'b0, 32'sd0},
    '{ROW_WRITE, CFG_INTEG_LIMIT, 24'h000064, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd5000, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd100, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sh8000, 16'sh7FFF, 1'b0, 32'sd0},
    // Writes to unmapped indexes change nothing.
    '{ROW_WRITE, CFG_SPARE_6, 24'hFFFFFF, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_WRITE, CFG_SPARE_7, 24'hFFFFFF, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sd0, -16'sd100, 1'b0, 32'sd0},
    // Widest dead zone swallows every error; upper data bits are dropped.
    '{ROW_WRITE, CFG_DEAD_ZONE, 24'hFFFFFF, 16'sd0, 16'sd0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_GAIN_P, 24'h000000, 16'sh7FFF, 16'sh8000, 1'b1, 32'sd0},
    '{ROW_WRITE, CFG_DEAD_ZONE, 24'd60, 16'sd0, 16'sd0, 1'b0, 32'sd0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppid_in_if sample_ch ();
  ppid_out_if drive_ch ();

  position_pid_deadzone_antiwindup u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in        (sample_ch),
    .out       (drive_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the registers and of the controller history.
  logic signed [GAIN_W-1:0] kp = '0;
  logic signed [GAIN_W-1:0] ki = '0;
  logic signed [GAIN_W-1:0] kd = '0;
  logic [DZ_W-1:0] dz = DEAD_ZONE_RST;
  logic [START_W-1:0] integ_start = INTEG_START_RST;
  logic [LIMIT_W-1:0] integ_limit = INTEG_LIMIT_RST;
  logic signed [ERR_W-1:0] integ_acc = '0;
  logic signed [ERR_W-1:0] prev_err = '0;

  logic signed [DRIVE_W-1:0] drive_q [$];
  logic signed [DRIVE_W-1:0] want_drive;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int wind_bias = 0;

  // Computes the drive value of one sample and advances the history.
  task automatic pid_predict(input logic signed [POS_W-1:0] tgt,
                             input logic signed [POS_W-1:0] meas,
                             output logic signed [DRIVE_W-1:0] drive);
    longint e, mag, acc, sum, q;
    e = longint'(tgt) - longint'(meas);
    mag = (e < 0) ? -e : e;
    if (mag <= longint'(dz)) begin
      e = 0;
      mag = 0;
      integ_acc = '0;
      prev_err = '0;
    end
    if (mag < longint'(integ_start)) begin
      acc = longint'(integ_acc) + e;
      if (acc > longint'(integ_limit)) begin
        acc = longint'(integ_limit);
      end else if (acc < -longint'(integ_limit)) begin
        acc = -longint'(integ_limit);
      end
      integ_acc = ERR_W'(acc);
    end
    sum = longint'(kp) * e + longint'(ki) * longint'(integ_acc)
        + longint'(kd) * (e - longint'(prev_err));
    prev_err = ERR_W'(e);
    q = sum >>> FRAC_W;
    if (q > longint'(DRIVE_MAX)) begin
      q = longint'(DRIVE_MAX);
    end else if (q < longint'(DRIVE_MIN)) begin
      q = longint'(DRIVE_MIN);
    end
    drive = DRIVE_W'(q);
  endtask

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int idle_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Register value for a random phase, with the extremes weighted in.
  function automatic logic [CFG_DATA_W-1:0] pick_reg(input logic [CFG_IDX_W-1:0] idx);
    int r;
    r = $urandom_range(0, 9);
    case (idx)
      CFG_DEAD_ZONE: begin
        if (r == 0) return '0;
        if (r == 1) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(0, 300));
      end
      CFG_INTEG_START: begin
        if (r == 0) return '0;
        if (r == 1) return CFG_DATA_W'({START_W{1'b1}});
        if (r == 2) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(0, 3000));
      end
      CFG_INTEG_LIMIT: begin
        if (r == 0) return '0;
        if (r == 1) return CFG_DATA_W'({LIMIT_W{1'b1}});
        if (r == 2) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(0, 2000));
      end
      default: begin
        // Gains: both extremes, zero, small values and the full range.
        if (r == 0) return {1'b1, {(CFG_DATA_W-1){1'b0}}};
        if (r == 1) return {1'b0, {(CFG_DATA_W-1){1'b1}}};
        if (r == 2) return '0;
        if (r < 6) return CFG_DATA_W'(int'($urandom_range(0, 393216)) - 196608);
        return CFG_DATA_W'($urandom);
      end
    endcase
  endfunction

  // Updates the shadow registers after a write; unmapped indexes are dropped.
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GAIN_P:      kp = data[GAIN_W-1:0];
      CFG_GAIN_I:      ki = data[GAIN_W-1:0];
      CFG_GAIN_D:      kd = data[GAIN_W-1:0];
      CFG_DEAD_ZONE:   dz = data[DZ_W-1:0];
      CFG_INTEG_START: integ_start = data[START_W-1:0];
      CFG_INTEG_LIMIT: integ_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every pending drive value has been taken, then writes one register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Offers one sample after an idle gap and records its drive value once taken.
  task automatic send_sample(input logic signed [POS_W-1:0] tgt,
                             input logic signed [POS_W-1:0] meas,
                             input int gap,
                             input logic known,
                             input logic signed [DRIVE_W-1:0] known_drive);
    logic signed [DRIVE_W-1:0] want;
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid = 1'b1;
    sample_ch.target = tgt;
    sample_ch.measured = meas;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    pid_predict(tgt, meas, want);
    if (known) begin
      want = known_drive;
    end
    drive_q.push_back(want);
  endtask

  // Random sample aimed at the dead zone edge, the integration threshold, a biased
  // moderate error that winds up the integral, the extremes or the full range.
  task automatic make_sample(output logic signed [POS_W-1:0] tgt,
                             output logic signed [POS_W-1:0] meas);
    int k, e, tv, mv;
    k = $urandom_range(0, 9);
    mv = int'($urandom_range(0, 65535)) + POS_MIN;
    if (k <= 2) begin
      e = int'(dz) + int'($urandom_range(0, 10)) - 5;
    end else if (k <= 4) begin
      e = int'(integ_start) + int'($urandom_range(0, 10)) - 5;
    end else begin
      e = wind_bias + int'($urandom_range(0, 2000)) - 1000;
    end
    if (k <= 4 && $urandom_range(0, 1) == 1) begin
      e = -e;
    end
    tv = mv + e;
    if (tv > POS_MAX || tv < POS_MIN) begin
      tv = (tv > POS_MAX) ? POS_MAX : POS_MIN;
      mv = tv - e;
      if (mv > POS_MAX) mv = POS_MAX;
      if (mv < POS_MIN) mv = POS_MIN;
    end
    if (k == 7) begin
      tv = ($urandom_range(0, 1) == 1) ? POS_MAX : POS_MIN;
      mv = ($urandom_range(0, 1) == 1) ? POS_MAX : POS_MIN;
    end else if (k >= 8) begin
      tv = int'($urandom_range(0, 65535)) + POS_MIN;
      mv = int'($urandom_range(0, 65535)) + POS_MIN;
    end
    tgt = POS_W'(tv);
    meas = POS_W'(mv);
  endtask

  // Drive channel back-pressure, changed on the falling edge.
  initial begin
    drive_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        drive_ch.ready = 1'b0;
        stall_left--;
      end else begin
        drive_ch.ready = 1'b1;
        stall_left = idle_len(rx_quiet);
      end
    end
  end

  // Compares every drive transfer with the oldest pending value.
  always @(posedge clk) begin
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      if (drive_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected drive transfer: actual %0d", drive_ch.drive);
        end
      end else begin
        want_drive = drive_q.pop_front();
        if (drive_ch.drive !== want_drive) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("drive mismatch: expected %0d, actual %0d", want_drive, drive_ch.drive);
          end
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Ends a run that hangs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    dir_row_t row;
    logic signed [POS_W-1:0] t_val, m_val;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_GAIN_P;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.target = '0;
    sample_ch.measured = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = directed_tbl[i];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.tgt, row.meas, idle_len(tx_quiet), row.known, row.drive);
      end
    end

    // Random phases, each with its own register setting and idling mix.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      wind_bias = int'($urandom_range(0, 600)) - 300;
      for (int r = 0; r <= int'(CFG_INTEG_LIMIT); r++) begin
        if (ph == 0 || $urandom_range(0, 2) != 0) begin
          write_reg(CFG_IDX_W'(r), pick_reg(CFG_IDX_W'(r)));
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                  CFG_DATA_W'($urandom));
      end
      repeat (PHASE_SAMPLES) begin
        make_sample(t_val, m_val);
        send_sample(t_val, m_val, idle_len(tx_quiet), 1'b0, '0);
      end
    end

    // Drain the pipeline, then keep watching for any stray transfer.
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
